// ===== rtl/clr_pkg.sv =====
package clr_pkg;

  // configuration register geometry
  localparam int unsigned IMG_DIM_BITS = 7;
  localparam logic [IMG_DIM_BITS-1:0] IMG_DIM_RESET = 7'd64;
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  // register index, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture a command beat
    logic setup;  // derive deltas, major axis and initial error
    logic emit;   // move current pixel to output register and advance
  } clr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic zero_len;   // line has no pixels
    logic last_step;  // current pixel is the final one
  } clr_status_t;

endpackage

// ===== rtl/clr_datapath.sv =====
module clr_datapath #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                                  clk,
  input  clr_pkg::clr_cmd_t                     cmd,
  output clr_pkg::clr_status_t                  status,
  input  logic [COORD_BITS-1:0]                 start_x,
  input  logic [COORD_BITS-1:0]                 start_y,
  input  logic [COORD_BITS-1:0]                 end_x,
  input  logic [COORD_BITS-1:0]                 end_y,
  input  logic [31:0]                           color,
  input  logic [clr_pkg::IMG_DIM_BITS-1:0]      image_width,
  input  logic [clr_pkg::IMG_DIM_BITS-1:0]      image_height,
  output logic [COORD_BITS-1:0]                 pixel_x,
  output logic [COORD_BITS-1:0]                 pixel_y,
  output logic [31:0]                           pixel_color,
  output logic                                  visible,
  output logic                                  last
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned CMP_BITS =
    (COORD_BITS > clr_pkg::IMG_DIM_BITS) ? COORD_BITS : clr_pkg::IMG_DIM_BITS;
  localparam logic [CB-1:0] ONE = CB'(1);

  // captured command
  logic [CB-1:0] sx, sy, ex, ey;
  logic [31:0]   col;

  // walk state
  logic          xmajor, x_neg, y_neg;
  logic [CB-1:0] len, mag, err, steps_left, cur_x, cur_y;

  // setup arithmetic
  logic [CB:0]   dx_raw, dy_raw, dx_inv, dy_inv;
  logic [CB-1:0] adx, ady, len_c, mag_c, err_init;
  logic          xmajor_c, minor_neg_c;

  // step arithmetic
  logic [CB:0]   err_sum, err_wrap;
  logic          wrap, step_x, step_y;
  logic          vis_x, vis_y;

  assign dx_raw = {1'b0, ex} - {1'b0, sx};
  assign dy_raw = {1'b0, ey} - {1'b0, sy};
  assign dx_inv = -dx_raw;
  assign dy_inv = -dy_raw;
  assign adx = dx_raw[CB] ? dx_inv[CB-1:0] : dx_raw[CB-1:0];
  assign ady = dy_raw[CB] ? dy_inv[CB-1:0] : dy_raw[CB-1:0];
  assign xmajor_c    = adx > ady;
  assign len_c       = xmajor_c ? adx : ady;
  assign mag_c       = xmajor_c ? ady : adx;
  assign minor_neg_c = xmajor_c ? dy_raw[CB] : dx_raw[CB];
  // rounding toward minus infinity on a negative minor axis
  assign err_init    = minor_neg_c ? (len_c - ONE) : '0;

  // err + mag stays below 2*len, so one subtract is enough
  assign err_sum  = {1'b0, err} + {1'b0, mag};
  assign wrap     = err_sum >= {1'b0, len};
  assign err_wrap = err_sum - {1'b0, len};
  assign step_x   = xmajor | wrap;
  assign step_y   = !xmajor | wrap;

  assign vis_x = CMP_BITS'(cur_x) < CMP_BITS'(image_width);
  assign vis_y = CMP_BITS'(cur_y) < CMP_BITS'(image_height);

  assign status.zero_len  = len_c == '0;
  assign status.last_step = steps_left == ONE;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx  <= start_x;
      sy  <= start_y;
      ex  <= end_x;
      ey  <= end_y;
      col <= color;
    end
    if (cmd.setup) begin
      xmajor     <= xmajor_c;
      x_neg      <= dx_raw[CB];
      y_neg      <= dy_raw[CB];
      len        <= len_c;
      mag        <= mag_c;
      err        <= err_init;
      steps_left <= len_c;
      cur_x      <= sx;
      cur_y      <= sy;
    end
    if (cmd.emit) begin
      pixel_x     <= cur_x;
      pixel_y     <= cur_y;
      pixel_color <= col;
      visible     <= vis_x & vis_y;
      last        <= steps_left == ONE;
      steps_left  <= steps_left - ONE;
      err         <= wrap ? err_wrap[CB-1:0] : err_sum[CB-1:0];
      if (step_x) begin
        cur_x <= x_neg ? (cur_x - ONE) : (cur_x + ONE);
      end
      if (step_y) begin
        cur_y <= y_neg ? (cur_y - ONE) : (cur_y + ONE);
      end
    end
  end

endmodule

// ===== rtl/clr_ctrl.sv =====
module clr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  output logic                 pix_valid,
  input  logic                 pix_ready,
  input  clr_pkg::clr_status_t status,
  output clr_pkg::clr_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free  = !pix_valid || pix_ready;
  assign cmd_ready = state == ST_IDLE;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:  cmd.load  = cmd_valid;
      ST_SETUP: cmd.setup = 1'b1;
      ST_RUN:   cmd.emit  = out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pix_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state <= status.zero_len ? ST_IDLE : ST_RUN;
        end
        ST_RUN: begin
          if (out_free && status.last_step) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/clipped_line_rasterizer_core.sv =====
// channel  | handshake               | beat contents
// ---------+-------------------------+------------------------------------------
// cmd      | cmd_valid / cmd_ready   | start_x, start_y, end_x, end_y, color
// pix      | pix_valid / pix_ready   | pixel_x, pixel_y, pixel_color, visible, last
// apb      | psel, penable, pready   | paddr, pwrite, pwdata, prdata
//
// a line is walked in steps: the cmd beat is captured in idle, a setup state derives deltas
// and initial error, then one pixel per cycle from an error add and compare in the datapath
// a stalled pix channel holds the walk; the next cmd beat is taken while the
// final pixel still waits in the output register
// a zero-length line gives no pix beat
// rst is synchronous; image size resets to 64 by 64
module clipped_line_rasterizer_core #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  // line commands
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  logic [COORD_BITS-1:0]             start_x,
  input  logic [COORD_BITS-1:0]             start_y,
  input  logic [COORD_BITS-1:0]             end_x,
  input  logic [COORD_BITS-1:0]             end_y,
  input  logic [31:0]                       color,
  // pixels
  output logic                              pix_valid,
  input  logic                              pix_ready,
  output logic [COORD_BITS-1:0]             pixel_x,
  output logic [COORD_BITS-1:0]             pixel_y,
  output logic [31:0]                       pixel_color,
  output logic                              visible,
  output logic                              last,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [clr_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [clr_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [clr_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  // clip window
  logic [clr_pkg::IMG_DIM_BITS-1:0] image_width;
  logic [clr_pkg::IMG_DIM_BITS-1:0] image_height;

  logic                 reg_wr;
  logic                 reg_idx;
  clr_pkg::clr_cmd_t    cmd;
  clr_pkg::clr_status_t status;

  // zero wait state, word address picks the register
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    prdata = '0;
    case (reg_idx)
      clr_pkg::REG_IMAGE_WIDTH:  prdata = clr_pkg::APB_DATA_BITS'(image_width);
      clr_pkg::REG_IMAGE_HEIGHT: prdata = clr_pkg::APB_DATA_BITS'(image_height);
      default:                   prdata = '0;
    endcase
  end

  // writes keep the low seven bits of the data
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= clr_pkg::IMG_DIM_RESET;
      image_height <= clr_pkg::IMG_DIM_RESET;
    end else if (reg_wr) begin
      if (reg_idx == clr_pkg::REG_IMAGE_WIDTH) begin
        image_width <= pwdata[clr_pkg::IMG_DIM_BITS-1:0];
      end
      if (reg_idx == clr_pkg::REG_IMAGE_HEIGHT) begin
        image_height <= pwdata[clr_pkg::IMG_DIM_BITS-1:0];
      end
    end
  end

  // sequencing: idle, setup, pixel walk
  clr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // deltas, error term, coordinates and the output register
  clr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .status       (status),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .color        (color),
    .image_width  (image_width),
    .image_height (image_height),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pixel_color),
    .visible      (visible),
    .last         (last)
  );

endmodule

// ===== rtl/clr_checker.sv =====
module clr_checker #(
  parameter int unsigned COORD_BITS = 6
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  cmd_valid,
  input logic                  cmd_ready,
  input logic                  pix_valid,
  input logic                  pix_ready,
  input logic [COORD_BITS-1:0] pixel_x,
  input logic [COORD_BITS-1:0] pixel_y,
  input logic [31:0]           pixel_color,
  input logic                  visible,
  input logic                  last
);

  // no pixel straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !pix_valid)
    else $error("pix_valid high after reset");

  // a taken command always leaves the core busy in the setup state
  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("cmd_ready high right after a command beat");

  // mid-line pixel on show means the line is still being walked
  a_mid_line: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !last) |-> !cmd_ready)
    else $error("cmd_ready high before the last pixel is produced");

  // stalled pixel beat holds
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix_ready) |=>
      (pix_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_color)
       && $stable(visible) && $stable(last)))
    else $error("stalled pixel beat changed");

endmodule

bind clipped_line_rasterizer_core clr_checker #(
  .COORD_BITS (COORD_BITS)
) u_clr_checker (.*);
